### src/circumcenter_three_points_defines.svh
// Assertion macros for the circumcenter block.
`ifndef CIRCUMCENTER_THREE_POINTS_DEFINES_SVH
`define CIRCUMCENTER_THREE_POINTS_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define CC3P_ASSERT(lbl, clk_sig, rstn_sig, prop) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
        else $error("cc3p check failed");

// Property checked on every clock edge, reset included.
`define CC3P_ASSERT_ALWAYS(lbl, clk_sig, prop) \
    lbl: assert property (@(posedge clk_sig) prop) \
        else $error("cc3p check failed");

`endif

### src/cc3p_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc3p_pkg
// Types and widths shared by the circumcenter pipeline.
// ----------------------------------------------------------------------------
package cc3p_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 2;         // 2*(b-a)
    localparam int SQ_W    = 2 * COORD_W;
    localparam int KC_W    = SQ_W + 2;            // sum of squares minus base
    localparam int DET_W   = 2 * DIFF_W + 1;
    localparam int NUM_W   = KC_W + DIFF_W + 1;
    localparam int THR_W   = 35;
    localparam int OUT_W   = 32;
    localparam int QB      = OUT_W + 1;           // quotient bits resolved by cells
    localparam int EXT_W   = NUM_W + QB;
    localparam int FRONT_STAGES = 5;              // input register plus four compute stages
    localparam int LATENCY = FRONT_STAGES + QB + 1;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by_coord;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
    } in_item_t;

    typedef struct packed {
        logic                    found;
        logic signed [OUT_W-1:0] center_x;
        logic signed [OUT_W-1:0] center_y;
        logic                    clipped;
    } out_item_t;

    typedef struct packed {
        logic             valid;
        logic             found;
        logic             neg_x;
        logic             neg_y;
        logic             ovf_x;
        logic             ovf_y;
        logic [DET_W-1:0] dmag;
        logic [NUM_W-1:0] rem_x;
        logic [NUM_W-1:0] rem_y;
        logic [QB-1:0]    q_x;
        logic [QB-1:0]    q_y;
    } div_item_t;

endpackage

### src/circumcenter_three_points.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circumcenter_three_points
// Circle center through three Q7.8 points by Cramer's rule, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  points    start / busy         in_item_t  (ax ay bx by_coord px py)
//  result    done (one cycle)     out_item_t (found center_x center_y clipped)
//  config    cfg_valid/cfg_ready  cfg_data   (min_det_magnitude)
//
//  One item per cycle while busy is low; each item passes through five
//  front stages (input register and four compute stages), 33 division cells
//  (one quotient bit each) and one output stage.
//  busy is high during reset and in the first cycle after reset release.
//  Reset clears the pipeline valids and sets the threshold to 1.
//  The receiver cannot stall; done pulses once per item.
// ----------------------------------------------------------------------------
module circumcenter_three_points
    import cc3p_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  in_item_t         points,
    output logic             done,
    output out_item_t        result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [THR_W-1:0] cfg_data
);

    logic [THR_W-1:0] thr_reg;
    logic             busy_reg;
    logic             done_reg;
    out_item_t        result_reg;
    div_item_t        chain [QB+1];

    logic             clip_x, clip_y;
    logic [OUT_W-1:0] val_x, val_y;

    localparam logic [QB-1:0] NEG_LIM = QB'(1) << (OUT_W - 1);
    localparam logic [QB-1:0] POS_LIM = NEG_LIM - QB'(1);

    assign busy      = busy_reg;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    cc3p_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy_reg),
        .in_item  (points),
        .thr      (thr_reg),
        .out_item (chain[0])
    );

    for (genvar k = 0; k < QB; k++)
    begin : g_cell
        cc3p_div_cell #(
            .BIT (QB - 1 - k)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .prev  (chain[k]),
            .next  (chain[k+1])
        );
    end

    always_comb
    begin
        clip_x = chain[QB].ovf_x ||
                 (chain[QB].neg_x ? (chain[QB].q_x > NEG_LIM) : (chain[QB].q_x > POS_LIM));
        clip_y = chain[QB].ovf_y ||
                 (chain[QB].neg_y ? (chain[QB].q_y > NEG_LIM) : (chain[QB].q_y > POS_LIM));
        if (clip_x)
            val_x = chain[QB].neg_x ? OUT_W'(NEG_LIM) : OUT_W'(POS_LIM);
        else
            val_x = chain[QB].neg_x ? OUT_W'(-chain[QB].q_x) : OUT_W'(chain[QB].q_x);
        if (clip_y)
            val_y = chain[QB].neg_y ? OUT_W'(NEG_LIM) : OUT_W'(POS_LIM);
        else
            val_y = chain[QB].neg_y ? OUT_W'(-chain[QB].q_y) : OUT_W'(chain[QB].q_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RESET;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= 1'b0;
            done_reg <= chain[QB].valid;
            if (cfg_valid && cfg_ready)
                thr_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.found    <= chain[QB].found;
        result_reg.center_x <= chain[QB].found ? $signed(val_x) : '0;
        result_reg.center_y <= chain[QB].found ? $signed(val_y) : '0;
        result_reg.clipped  <= chain[QB].found && (clip_x || clip_y);
    end

endmodule

### src/cc3p_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc3p_front
// Five-stage front end: input register, differences, squares, determinant,
// numerators, signs.
// ----------------------------------------------------------------------------
module cc3p_front
    import cc3p_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  in_item_t         in_item,
    input  logic [THR_W-1:0] thr,
    output div_item_t        out_item
);

    // stage 1
    logic     v1_reg;
    in_item_t p1_reg;
    // stage 2
    logic                     v2_reg;
    logic signed [DIFF_W-1:0] ka2_reg, kb2_reg, kd2_reg, ke2_reg;
    logic signed [SQ_W:0]     sb2_reg, sp2_reg, sa2_reg;
    // stage 3
    logic                     v3_reg;
    logic signed [DIFF_W-1:0] ka3_reg, kb3_reg, kd3_reg, ke3_reg;
    logic signed [KC_W-1:0]   kc3_reg, kf3_reg;
    logic signed [2*DIFF_W-1:0] pa3_reg, pb3_reg;
    // stage 4
    logic                     v4_reg;
    logic signed [DET_W-1:0]  det4_reg;
    logic signed [NUM_W-2:0]  m1_reg, m2_reg, m3_reg, m4_reg;

    logic signed [COORD_W:0]  u, v, s, t;
    logic signed [DIFF_W-1:0] ka, kb, kd, ke;
    logic signed [SQ_W-1:0]   sqax, sqay, sqbx, sqby, sqpx, sqpy;
    logic signed [NUM_W-1:0]  numx, numy;
    logic [NUM_W-1:0]         magx, magy;
    logic [DET_W-1:0]         dmag;

    always_comb
    begin
        u  = (COORD_W+1)'(p1_reg.bx) - (COORD_W+1)'(p1_reg.ax);
        v  = (COORD_W+1)'(p1_reg.by_coord) - (COORD_W+1)'(p1_reg.ay);
        s  = (COORD_W+1)'(p1_reg.px) - (COORD_W+1)'(p1_reg.ax);
        t  = (COORD_W+1)'(p1_reg.py) - (COORD_W+1)'(p1_reg.ay);
        ka = $signed({u, 1'b0});
        kb = $signed({v, 1'b0});
        kd = $signed({s, 1'b0});
        ke = $signed({t, 1'b0});
        sqax = p1_reg.ax * p1_reg.ax;
        sqay = p1_reg.ay * p1_reg.ay;
        sqbx = p1_reg.bx * p1_reg.bx;
        sqby = p1_reg.by_coord * p1_reg.by_coord;
        sqpx = p1_reg.px * p1_reg.px;
        sqpy = p1_reg.py * p1_reg.py;
    end

    always_comb
    begin
        numx = NUM_W'(m1_reg) - NUM_W'(m2_reg);
        numy = NUM_W'(m3_reg) - NUM_W'(m4_reg);
        magx = numx[NUM_W-1] ? NUM_W'(-numx) : NUM_W'(numx);
        magy = numy[NUM_W-1] ? NUM_W'(-numy) : NUM_W'(numy);
        dmag = det4_reg[DET_W-1] ? DET_W'(-det4_reg) : DET_W'(det4_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            out_item <= '0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            out_item.valid <= v4_reg;
            out_item.found <= (dmag != '0) && (dmag >= DET_W'(thr));
            out_item.neg_x <= numx[NUM_W-1] ^ det4_reg[DET_W-1];
            out_item.neg_y <= numy[NUM_W-1] ^ det4_reg[DET_W-1];
            out_item.ovf_x <= EXT_W'(magx) >= (EXT_W'(dmag) << QB);
            out_item.ovf_y <= EXT_W'(magy) >= (EXT_W'(dmag) << QB);
            out_item.dmag  <= dmag;
            out_item.rem_x <= magx;
            out_item.rem_y <= magy;
            out_item.q_x   <= '0;
            out_item.q_y   <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg  <= in_item;

        ka2_reg <= ka;
        kb2_reg <= kb;
        kd2_reg <= kd;
        ke2_reg <= ke;
        sb2_reg <= (SQ_W+1)'(sqbx) + (SQ_W+1)'(sqby);
        sp2_reg <= (SQ_W+1)'(sqpx) + (SQ_W+1)'(sqpy);
        sa2_reg <= (SQ_W+1)'(sqax) + (SQ_W+1)'(sqay);

        ka3_reg <= ka2_reg;
        kb3_reg <= kb2_reg;
        kd3_reg <= kd2_reg;
        ke3_reg <= ke2_reg;
        kc3_reg <= KC_W'(sb2_reg) - KC_W'(sa2_reg);
        kf3_reg <= KC_W'(sp2_reg) - KC_W'(sa2_reg);
        pa3_reg <= ka2_reg * ke2_reg;
        pb3_reg <= kb2_reg * kd2_reg;

        det4_reg <= DET_W'(pa3_reg) - DET_W'(pb3_reg);
        m1_reg   <= kc3_reg * ke3_reg;
        m2_reg   <= kb3_reg * kf3_reg;
        m3_reg   <= ka3_reg * kf3_reg;
        m4_reg   <= kc3_reg * kd3_reg;
    end

endmodule

### src/cc3p_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc3p_div_cell
// One restoring-division cell: resolves quotient bit BIT of both lanes.
// ----------------------------------------------------------------------------
module cc3p_div_cell
    import cc3p_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_item_t prev,
    output div_item_t next
);

    logic [EXT_W-1:0] dsh;
    logic             gex, gey;

    always_comb
    begin
        dsh = EXT_W'(prev.dmag) << BIT;
        gex = EXT_W'(prev.rem_x) >= dsh;
        gey = EXT_W'(prev.rem_y) >= dsh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            next <= '0;
        else
        begin
            next.valid <= prev.valid;
            next.found <= prev.found;
            next.neg_x <= prev.neg_x;
            next.neg_y <= prev.neg_y;
            next.ovf_x <= prev.ovf_x;
            next.ovf_y <= prev.ovf_y;
            next.dmag  <= prev.dmag;
            next.rem_x <= gex ? NUM_W'(EXT_W'(prev.rem_x) - dsh) : prev.rem_x;
            next.rem_y <= gey ? NUM_W'(EXT_W'(prev.rem_y) - dsh) : prev.rem_y;
            next.q_x   <= prev.q_x | (QB'(gex) << BIT);
            next.q_y   <= prev.q_y | (QB'(gey) << BIT);
        end
    end

endmodule

### src/cc3p_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc3p_checker
// Port-level checks on the circumcenter block, bound to the top level.
// ----------------------------------------------------------------------------
`include "circumcenter_three_points_defines.svh"

module cc3p_checker
    import cc3p_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      done,
    input out_item_t result
);

    `CC3P_ASSERT(a_item_latency, clk, rst_n, (start && !busy) |-> ##LATENCY done)
    `CC3P_ASSERT(a_no_spurious, clk, rst_n, done |-> $past(start && !busy, LATENCY))
    `CC3P_ASSERT(a_collinear_zero, clk, rst_n, (done && !result.found) |-> (result.center_x == 0 && result.center_y == 0 && !result.clipped))
    `CC3P_ASSERT_ALWAYS(a_busy_after_reset, clk, $rose(rst_n) |-> busy)

endmodule

bind circumcenter_three_points cc3p_checker u_cc3p_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
